/* rtl/sams_pkg.sv */
// shared types and codes of the shared-array multi-stack
`default_nettype none
package sams_pkg;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   // stack ids that the request word can carry
   localparam int STACK_IDS = 4;

   // request word
   typedef struct packed {
      logic               op;
      logic [1:0]         stack_id;
      logic signed [31:0] value;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
   } rsp_word_type;

endpackage
`default_nettype wire

/* rtl/sams_slot_ram.sv */
// single-port-write, single-port-read slot memory with registered read data
`default_nettype none
module sams_slot_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/shared_array_multi_stack.sv */
// top level: stacks linked through a shared slot memory with one free list
// NUM_STACKS stacks (up to four addressable) share NUM_SLOTS slots held in two
// synchronous memories, one for data words and one for link words. A push or
// pop that finds a slot works in phases: the accept cycle reads the slot's
// link (and data for a pop) from memory, the next cycle writes the links back
// and registers the response word. A push with no free slot, a pop of an empty
// stack, or a stack id at or beyond NUM_STACKS is answered in the accept cycle
// itself. Slots never yet handed out are tracked by a fill count, so the link
// memory needs no clearing after reset and a request can be taken in the
// cycle after reset. The response sits in an output register; the next
// request is taken once the previous one has finished and that register is
// free or being drained.
`default_nettype none
module shared_array_multi_stack
   import sams_pkg::*;
#(
   parameter int NUM_SLOTS  = 16,
   parameter int NUM_STACKS = 4,
   parameter int DATA_BITS  = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int LINK_BITS    = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
   localparam int TOP_DEPTH    = (NUM_STACKS < STACK_IDS) ? NUM_STACKS : STACK_IDS;
   localparam int TOP_IDX_BITS = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
   localparam logic [LINK_BITS-1:0] LINK_NULL = LINK_BITS'(NUM_SLOTS);

   localparam logic PH_IDLE = 1'b0;
   localparam logic PH_EXEC = 1'b1;

   // control and state registers
   logic                    phase_ff, phase_in;
   logic [LINK_BITS-1:0]    free_head_ff, free_head_in;
   logic [LINK_BITS-1:0]    fill_ff, fill_in;
   logic [LINK_BITS-1:0]    top_ff [TOP_DEPTH];
   logic [LINK_BITS-1:0]    top_in [TOP_DEPTH];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_ff, rsp_in;

   // operation held between the read and write-back cycles
   logic                    op_ff, op_in;
   logic [TOP_IDX_BITS-1:0] idx_ff, idx_in;
   logic [SLOT_BITS-1:0]    slot_ff, slot_in;
   logic [DATA_BITS-1:0]    value_ff, value_in;

   // memory ports
   logic                    link_wr_en;
   logic [LINK_BITS-1:0]    link_wr_data;
   logic [LINK_BITS-1:0]    link_rd_data;
   logic                    data_wr_en;
   logic [DATA_BITS-1:0]    data_rd_data;
   logic                    mem_rd_en;
   logic [SLOT_BITS-1:0]    mem_rd_addr;

   // accept-cycle decode
   logic                    req_fire;
   logic                    sid_ok;
   logic [TOP_IDX_BITS-1:0] req_idx;
   logic [LINK_BITS-1:0]    top_sel;
   logic [LINK_BITS-1:0]    slot_cand;
   logic                    slot_found;

   // write-back decode
   logic [LINK_BITS-1:0]    slot_ext;
   logic [LINK_BITS-1:0]    link_next;
   logic signed [DATA_BITS-1:0] data_signed;

   sams_slot_ram #(
      .WIDTH     (LINK_BITS),
      .DEPTH     (NUM_SLOTS),
      .ADDR_BITS (SLOT_BITS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (slot_ff),
      .wr_data (link_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (link_rd_data)
   );

   sams_slot_ram #(
      .WIDTH     (DATA_BITS),
      .DEPTH     (NUM_SLOTS),
      .ADDR_BITS (SLOT_BITS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (slot_ff),
      .wr_data (value_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (data_rd_data)
   );

   // handshake
   assign req_stall = (phase_ff == PH_EXEC) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // pick the slot the request works on
   always_comb begin
      sid_ok  = int'(req_word.stack_id) < TOP_DEPTH;
      req_idx = req_word.stack_id[TOP_IDX_BITS-1:0];
      top_sel = sid_ok ? top_ff[req_idx] : LINK_NULL;
      if (req_word.op == OP_PUSH) begin
         slot_cand  = free_head_ff;
         slot_found = sid_ok && (free_head_ff != LINK_NULL);
      end else begin
         slot_cand  = top_sel;
         slot_found = top_sel != LINK_NULL;
      end
      mem_rd_en   = req_fire && slot_found;
      mem_rd_addr = slot_cand[SLOT_BITS-1:0];
   end

   // link of the slot; untouched slots chain to the next index
   always_comb begin
      slot_ext    = LINK_BITS'(slot_ff);
      link_next   = (slot_ext >= fill_ff) ? LINK_BITS'(slot_ext + 1'b1) : link_rd_data;
      data_signed = data_rd_data;
   end

   // write-back memory ports
   always_comb begin
      link_wr_en   = (phase_ff == PH_EXEC);
      data_wr_en   = (phase_ff == PH_EXEC) && (op_ff == OP_PUSH);
      link_wr_data = (op_ff == OP_PUSH) ? top_ff[idx_ff] : free_head_ff;
   end

   // next state
   always_comb begin
      phase_in     = phase_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_fire) begin
               if (slot_found) begin
                  phase_in = PH_EXEC;
                  op_in    = req_word.op;
                  idx_in   = req_idx;
                  slot_in  = slot_cand[SLOT_BITS-1:0];
                  value_in = DATA_BITS'(req_word.value);
               end else begin
                  rsp_valid_in = 1'b1;
                  if (req_word.op == OP_PUSH) begin
                     rsp_in.popped_value = '0;
                     rsp_in.status       = STATUS_OVERFLOW;
                  end else begin
                     rsp_in.popped_value = '1;
                     rsp_in.status       = STATUS_UNDERFLOW;
                  end
               end
            end
         end
         PH_EXEC: begin
            phase_in     = PH_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.status = STATUS_OK;
            if (op_ff == OP_PUSH) begin
               free_head_in        = link_next;
               top_in[idx_ff]      = slot_ext;
               rsp_in.popped_value = '0;
               if (slot_ext == fill_ff) begin
                  fill_in = LINK_BITS'(fill_ff + 1'b1);
               end
            end else begin
               top_in[idx_ff]      = link_next;
               free_head_in        = slot_ext;
               rsp_in.popped_value = 32'(data_signed);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TOP_DEPTH; i++) begin
            top_ff[i] <= LINK_NULL;
         end
      end else begin
         phase_ff     <= phase_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      slot_ff  <= slot_in;
      value_ff <= value_in;
   end

endmodule
`default_nettype wire
